// File: hw/rtl/tsfd_pkg.sv
// Shared types and constants for the touch sample queue.
// Used by tsfd_ctrl, tsfd_dp and touch_sample_fifo_dedup; no dependencies.
package tsfd_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int LVL_W           = 7;
    localparam logic [15:0] PEN_THRESH_RST = 16'd9000;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] press;
        logic [47:0] stamp;
    } touch_in_t;

    typedef struct packed {
        logic             done_flag;
        logic [15:0]      out_x;
        logic [15:0]      out_y;
        logic [15:0]      out_press;
        logic [47:0]      out_stamp;
        logic [LVL_W-1:0] fill_level;
    } touch_out_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] p;
        logic [47:0] t;
    } ring_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

endpackage

// File: hw/rtl/tsfd_ctrl.sv
// Controller for the touch sample queue: sequences accept, ring read and commit.
// Depends on tsfd_pkg.
module tsfd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tsfd_pkg::ctrl_cmd_t cmd
);

    tsfd_pkg::ctrl_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tsfd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tsfd_pkg::ST_READ;
                end
            end
            tsfd_pkg::ST_READ: begin
                state_next = tsfd_pkg::ST_EXEC;
            end
            tsfd_pkg::ST_EXEC: begin
                if (slot_free) begin
                    state_next = tsfd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tsfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            tsfd_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            tsfd_pkg::ST_READ: begin
            end
            tsfd_pkg::ST_EXEC: begin
                cmd.commit = slot_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tsfd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: hw/rtl/tsfd_dp.sv
// Datapath for the touch sample queue: ring memory, head/count, held point,
// threshold register, duplicate compare and result register. Depends on tsfd_pkg.
module tsfd_dp #(
    parameter int QUEUE_DEPTH = tsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tsfd_pkg::ctrl_cmd_t   cmd,
    input  tsfd_pkg::touch_in_t   s_data,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    output tsfd_pkg::touch_out_t  m_data
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    tsfd_pkg::ring_entry_t ring_mem [QUEUE_DEPTH];
    tsfd_pkg::ring_entry_t rdata_reg;
    tsfd_pkg::touch_in_t   in_reg;
    tsfd_pkg::touch_out_t  out_reg, out_next;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [15:0]       held_x_reg, held_y_reg, held_p_reg;
    logic [15:0]       held_x_next, held_y_next, held_p_next;
    logic [15:0]       thresh_reg;

    logic [SUM_W-1:0]  head_ext, newest_sum, newest_idx, wr_sum, wr_idx, head_inc;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              is_pop, empty, full, s_pen, held_pen, n_pen, dup, keep, mem_we;
    logic [15:0]       smp_x, smp_y;

    assign head_ext   = SUM_W'(head_reg);
    assign newest_sum = head_ext + SUM_W'(count_reg) - SUM_W'(1);
    assign newest_idx = (newest_sum >= DEPTH_S) ? newest_sum - DEPTH_S : newest_sum;
    assign wr_sum     = head_ext + SUM_W'(count_reg);
    assign wr_idx     = (wr_sum >= DEPTH_S) ? wr_sum - DEPTH_S : wr_sum;
    assign head_inc   = head_ext + SUM_W'(1);

    assign is_pop  = (in_reg.op == tsfd_pkg::OP_POP);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == DEPTH_C);
    assign rd_addr = is_pop ? head_reg : newest_idx[ADDR_W-1:0];
    assign wr_addr = empty ? '0 : wr_idx[ADDR_W-1:0];

    assign s_pen    = (in_reg.press != 16'd0) && (in_reg.press < thresh_reg);
    assign held_pen = (held_p_reg != 16'd0) && (held_p_reg < thresh_reg);
    assign n_pen    = (rdata_reg.p != 16'd0) && (rdata_reg.p < thresh_reg);

    always_comb begin
        smp_x = in_reg.pos_x;
        smp_y = in_reg.pos_y;
        if (!s_pen && held_pen) begin
            smp_x = held_x_reg;
            smp_y = held_y_reg;
        end
    end

    assign dup    = !empty && (rdata_reg.x == smp_x) && (rdata_reg.y == smp_y)
                    && (n_pen == s_pen);
    assign keep   = !full && !dup;
    assign mem_we = cmd.commit && !is_pop && keep;

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        held_p_next = held_p_reg;
        out_next    = '0;
        if (is_pop) begin
            if (!empty) begin
                count_next         = count_reg - CNT_W'(1);
                head_next          = (count_reg == CNT_W'(1) || head_inc == DEPTH_S)
                                     ? '0 : head_inc[ADDR_W-1:0];
                out_next.done_flag = 1'b1;
                out_next.out_x     = rdata_reg.x;
                out_next.out_y     = rdata_reg.y;
                out_next.out_press = rdata_reg.p;
                out_next.out_stamp = rdata_reg.t;
            end else begin
                out_next.out_x     = held_x_reg;
                out_next.out_y     = held_y_reg;
                out_next.out_press = held_p_reg;
                out_next.out_stamp = in_reg.stamp;
            end
        end else begin
            if (s_pen) begin
                held_x_next = in_reg.pos_x;
                held_y_next = in_reg.pos_y;
                held_p_next = in_reg.press;
            end
            if (keep) begin
                count_next         = count_reg + CNT_W'(1);
                out_next.done_flag = 1'b1;
                if (empty) begin
                    head_next = '0;
                end
            end
        end
        out_next.fill_level = tsfd_pkg::LVL_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= ring_mem[rd_addr];
        if (mem_we) begin
            ring_mem[wr_addr] <= '{x: smp_x, y: smp_y, p: in_reg.press, t: in_reg.stamp};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            count_reg  <= '0;
            held_x_reg <= '0;
            held_y_reg <= '0;
            held_p_reg <= '0;
            thresh_reg <= tsfd_pkg::PEN_THRESH_RST;
        end else begin
            if (cmd.commit) begin
                head_reg   <= head_next;
                count_reg  <= count_next;
                held_x_reg <= held_x_next;
                held_y_reg <= held_y_next;
                held_p_reg <= held_p_next;
            end
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
        end
    end

    assign m_data = out_reg;

endmodule

// File: hw/rtl/touch_sample_fifo_dedup.sv
// Touch sample queue with duplicate suppression. Each transfer (push or pop)
// is accepted, then reads the ring memory through a registered read (newest
// entry on a push, oldest on a pop), then is compared and committed into the
// result register. A new transfer is accepted while a result still waits,
// but commit holds until that result has been taken. Pen-down is
// 0 < pressure < threshold; the threshold is written through cfg_wr_en and takes
// effect once registered, also for a transfer still in flight. No clearing pass is
// needed after reset. Depends on tsfd_pkg, tsfd_ctrl and tsfd_dp.
module touch_sample_fifo_dedup #(
    parameter int QUEUE_DEPTH = tsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tsfd_pkg::touch_in_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tsfd_pkg::touch_out_t m_data,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data
);

    tsfd_pkg::ctrl_cmd_t cmd;

    tsfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tsfd_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_data      (m_data)
    );

endmodule

// File: tb/tsfd_checker.sv
// Scoreboard for touch_sample_fifo_dedup: watches the sample, result and threshold ports,
// keeps its own copy of the queue and compares every result transfer in order.
// Depends on tsfd_pkg.
module tsfd_checker
    import tsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  touch_in_t  s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  touch_out_t m_data,
    input  logic       cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int         pending,
    output int         mismatches
);

    localparam int unsigned QDEPTH = QUEUE_DEPTH_DEF;

    ring_entry_t  slots [QDEPTH];
    ring_entry_t  held;
    int unsigned  head;
    int unsigned  count;
    logic [15:0]  thresh;
    touch_out_t   predicted_replies [$];
    int           fail_cnt;

    function automatic logic pen_down(input logic [15:0] p);
        return (p != 16'd0) && (p < thresh);
    endfunction

    function automatic touch_out_t predict_queue_reply(input touch_in_t smp);
        touch_out_t  r;
        ring_entry_t e;
        ring_entry_t newest;
        logic        keep;
        r = '0;
        if (smp.op == OP_PUSH) begin
            e.x = smp.pos_x;
            e.y = smp.pos_y;
            e.p = smp.press;
            e.t = smp.stamp;
            if (pen_down(e.p)) begin
                held = e;
            end else if (pen_down(held.p)) begin
                e.x = held.x;
                e.y = held.y;
            end
            if (count < QDEPTH) begin
                keep = 1'b1;
                if (count > 0) begin
                    newest = slots[(head + count - 1) % QDEPTH];
                    if (newest.x == e.x && newest.y == e.y &&
                        pen_down(newest.p) == pen_down(e.p)) begin
                        keep = 1'b0;
                    end
                end
                if (keep) begin
                    if (count == 0) head = 0;
                    slots[(head + count) % QDEPTH] = e;
                    count++;
                    r.done_flag = 1'b1;
                end
            end
        end else begin
            if (count > 0) begin
                e = slots[head];
                r.out_x     = e.x;
                r.out_y     = e.y;
                r.out_press = e.p;
                r.out_stamp = e.t;
                count--;
                head = (count == 0) ? 0 : (head + 1) % QDEPTH;
                r.done_flag = 1'b1;
            end else begin
                r.out_x     = held.x;
                r.out_y     = held.y;
                r.out_press = held.p;
                r.out_stamp = smp.stamp;
            end
        end
        r.fill_level = count[LVL_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        touch_out_t want;
        if (!aresetn) begin
            head   = 0;
            count  = 0;
            held   = '0;
            thresh = PEN_THRESH_RST;
            predicted_replies.delete();
            fail_cnt = 0;
        end else begin
            if (cfg_wr_en) thresh = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result transfer: %p", m_data);
                end else begin
                    want = predicted_replies.pop_front();
                    if (m_data.done_flag !== want.done_flag ||
                        m_data.out_x !== want.out_x ||
                        m_data.out_y !== want.out_y ||
                        m_data.out_press !== want.out_press ||
                        m_data.out_stamp !== want.out_stamp ||
                        m_data.fill_level !== want.fill_level) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("mismatch exp: done=%0d x=%h y=%h p=%h t=%h lvl=%0d",
                                     want.done_flag, want.out_x, want.out_y,
                                     want.out_press, want.out_stamp, want.fill_level);
                            $display("         got: done=%0d x=%h y=%h p=%h t=%h lvl=%0d",
                                     m_data.done_flag, m_data.out_x, m_data.out_y,
                                     m_data.out_press, m_data.out_stamp, m_data.fill_level);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                predicted_replies.push_back(predict_queue_reply(s_data));
        end
        pending    <= predicted_replies.size();
        mismatches <= fail_cnt;
    end

endmodule

// File: tb/tb_touch_sample_fifo_dedup.sv
// Top of the touch_sample_fifo_dedup testbench: clock, reset, sample traffic,
// result back-pressure and the verdict. Depends on tsfd_pkg, tsfd_checker and the RTL.
module tb_touch_sample_fifo_dedup;
    import tsfd_pkg::*;

    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 190;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    touch_in_t   s_data;
    logic        m_valid;
    logic        m_ready;
    touch_out_t  m_data;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    int          pending;
    int          mismatches;
    int          stall_asks;
    int          quiet_cycles;
    int          burst_left;
    logic [15:0] cur_thresh;

    touch_sample_fifo_dedup dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    tsfd_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic touch_in_t mk_sample(input logic op, input logic [15:0] x,
                                            input logic [15:0] y, input logic [15:0] p,
                                            input logic [47:0] t);
        touch_in_t s;
        s.op    = op;
        s.pos_x = x;
        s.pos_y = y;
        s.press = p;
        s.stamp = t;
        return s;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, 3));
            4:          return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_press();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return cur_thresh - 16'd1;
            2:       return cur_thresh;
            3:       return cur_thresh + 16'd1;
            4:       return 16'hFFFF;
            5:       return 16'd1;
            6, 7:    return (cur_thresh > 16'd1) ? 16'($urandom_range(1, cur_thresh - 1))
                                                 : 16'($urandom);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic touch_in_t rand_sample(input int push_pct);
        logic [47:0] t;
        case ($urandom_range(0, 15))
            0:       t = '0;
            1:       t = '1;
            default: t = {16'($urandom), 32'($urandom)};
        endcase
        return mk_sample(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                         rand_coord(), rand_coord(), rand_press(), t);
    endfunction

    // valid and payload held until the transfer completes
    task automatic send_item(input touch_in_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random(input int n, input int push_pct, input int hold_at);
        int i;
        int gap;
        for (i = 0; i < n; i++) begin
            if (i == hold_at) stall_asks++;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            send_item(rand_sample(push_pct));
        end
    endtask

    // pending is a registered copy of the checker's count of outstanding results
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_thresh(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_thresh  = v;
    endtask

    initial begin : stimulus
        int ph;
        logic [15:0] thr_list [PHASES];
        int pct_list [PHASES];
        thr_list = '{16'd0, 16'hFFFF, 16'd1, 16'd9000, 16'($urandom), 16'($urandom),
                     16'd2, 16'($urandom)};
        pct_list = '{50, 90, 30, 95, 60, 50, 75, 40};
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        stall_asks  = 0;
        burst_left  = 0;
        cur_thresh  = PEN_THRESH_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pops, pen-up/pen-down boundaries, held-point substitution, duplicates
        send_item(mk_sample(OP_POP,  16'h0000, 16'h0000, 16'h0000, 48'h0));
        send_item(mk_sample(OP_POP,  16'hFFFF, 16'hFFFF, 16'hFFFF, '1));
        send_item(mk_sample(OP_PUSH, 16'h0000, 16'h0000, 16'h0000, 48'h0));
        send_item(mk_sample(OP_PUSH, 16'h0000, 16'h0000, 16'h0000, 48'h1));
        send_item(mk_sample(OP_PUSH, 16'hFFFF, 16'hFFFF, 16'd1,    '1));
        send_item(mk_sample(OP_PUSH, 16'd1,    16'd2,    16'd8999, 48'h10));
        send_item(mk_sample(OP_PUSH, 16'd3,    16'd4,    16'd9000, 48'h11));
        send_item(mk_sample(OP_PUSH, 16'd5,    16'd6,    16'hFFFF, 48'h12));
        send_item(mk_sample(OP_PUSH, 16'd1,    16'd2,    16'd100,  48'h13));
        send_item(mk_sample(OP_PUSH, 16'd1,    16'd2,    16'd200,  48'h14));
        send_item(mk_sample(OP_PUSH, 16'hAAAA, 16'h5555, 16'd9001, 48'h5555_AAAA_5555));
        repeat (7) send_item(mk_sample(OP_POP, 16'h0, 16'h0, 16'h0, 48'hAAAA_5555_AAAA));
        send_item(mk_sample(OP_PUSH, 16'h5555, 16'hAAAA, 16'd4000, 48'h20));
        send_item(mk_sample(OP_PUSH, 16'h5555, 16'hAAAA, 16'd0,    48'h21));
        repeat (3) send_item(mk_sample(OP_POP, 16'h0, 16'h0, 16'h0, 48'h22));

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            write_thresh(thr_list[ph]);
            send_random(PHASE_LEN, pct_list[ph], (ph == 1 || ph == 3) ? 40 : -1);
        end
        drain();
        repeat (16) @(posedge aclk);

        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : result_side
        int mode;
        int left;
        int stall_seen;
        m_ready    = 1'b0;
        mode       = 0;
        left       = 0;
        stall_seen = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (stall_asks != stall_seen) begin
                stall_seen = stall_asks;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= left[2];
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
